// ===== design/fat12_pkg.sv =====
`timescale 1ns / 1ps

package fat12_pkg;

  // Request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_FOLLOW = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] REG_SECTORS_PER_TABLE   = 3'd3;
  localparam logic [2:0] REG_TABLE_COPIES        = 3'd4;
  localparam logic [2:0] REG_ROOT_ENTRY_COUNT    = 3'd5;

  // Root directory bytes: 16-bit entry count times 32
  localparam int unsigned RootBytesWidth = 21;

  // End-of-chain marker threshold
  localparam logic [11:0] END_OF_CHAIN_MIN = 12'hFF8;

  typedef struct packed {
    logic        func;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [11:0] cluster;
  } in_req_t;

  typedef struct packed {
    logic [31:0] sector_address;
    logic [11:0] next_cluster;
    logic        end_of_chain;
    logic        bad_cluster;
  } out_rsp_t;

endpackage

// ===== design/fat12_chain_lba_follow.sv =====
// FAT12 cluster chain follower. A load request (func 0) writes one byte of
// the allocation table into the internal store and gives no response. A
// follow request (func 1) reads the 12-bit entry of the named cluster from
// two adjacent table bytes and returns the cluster's first sector, the next
// cluster, an end-of-chain flag (next cluster 0xFF8 or more) and a
// bad-cluster flag (cluster below 2, sector 0). The root directory sector
// count is found by a restoring divider that retires one quotient bit per
// cycle, 21 quotient bits in all, then one shared 16x8 multiplier and adder
// take three more steps before the response register. The block stalls
// requests while a follow is in work; the store is undefined until loaded.
`timescale 1ns / 1ps

module fat12_chain_lba_follow #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fat12_pkg::in_req_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fat12_pkg::out_rsp_t  out_rsp_o
);

  localparam int unsigned AW        = $clog2(TABLE_BYTES);
  localparam int unsigned DivSteps  = fat12_pkg::RootBytesWidth;
  localparam int unsigned CntWidth  = $clog2(DivSteps);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MULA = 3'd2;
  localparam logic [2:0] ST_MULB = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]  state_q, state_d;

  // Configuration registers
  logic [12:0] bps_q;
  logic [7:0]  spc_q;
  logic [15:0] rsv_q;
  logic [15:0] spt_q;
  logic [7:0]  copies_q;
  logic [15:0] root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= 13'd512;
      spc_q    <= 8'd1;
      rsv_q    <= 16'd1;
      spt_q    <= 16'd9;
      copies_q <= 8'd2;
      root_q   <= 16'd224;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fat12_pkg::REG_BYTES_PER_SECTOR:    bps_q    <= cfg_data_i[12:0];
        fat12_pkg::REG_SECTORS_PER_CLUSTER: spc_q    <= cfg_data_i[7:0];
        fat12_pkg::REG_RESERVED_SECTORS:    rsv_q    <= cfg_data_i;
        fat12_pkg::REG_SECTORS_PER_TABLE:   spt_q    <= cfg_data_i;
        fat12_pkg::REG_TABLE_COPIES:        copies_q <= cfg_data_i[7:0];
        fat12_pkg::REG_ROOT_ENTRY_COUNT:    root_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request handshake
  logic in_acc;
  logic is_follow;
  logic out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_follow  = (in_req_i.func == fat12_pkg::FUNC_FOLLOW);
  assign out_free   = !out_valid_o || !out_stall_i;

  // Table store addressing: entry offset is cluster + cluster/2
  logic [12:0]   offset_in;
  logic [12:0]   offset_q;
  logic [AW:0]   wr_ext;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  assign offset_in = {1'b0, in_req_i.cluster} + {2'b00, in_req_i.cluster[11:1]};
  assign wr_ext    = (AW + 1)'(in_req_i.table_address);

  // Wrap load addresses beyond the store
  always_comb begin
    if (wr_ext >= (AW + 1)'(TABLE_BYTES)) begin
      wr_addr = AW'(wr_ext - (AW + 1)'(TABLE_BYTES));
    end else begin
      wr_addr = AW'(wr_ext);
    end
  end

  assign mem_we  = in_acc && !is_follow;
  assign rd_addr = (state_q == ST_IDLE) ? AW'(offset_in) : AW'(offset_q + 13'd1);

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rdata_q;

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= in_req_i.table_byte;
    end
    rdata_q <= mem[rd_addr];
  end

  // Datapath registers
  logic [11:0]         cluster_q;
  logic [7:0]          lo_q;
  logic [12:0]         rem_q;
  logic [DivSteps-1:0] quo_q;
  logic [CntWidth-1:0] cnt_q;
  logic [23:0]         mprod_q;
  logic [31:0]         acc_q;

  // Restoring divide step
  logic [13:0] trial;
  logic        fits;
  logic [12:0] rem_next;

  assign trial    = {rem_q, quo_q[DivSteps-1]};
  assign fits     = (trial >= {1'b0, bps_q});
  assign rem_next = fits ? 13'(trial - {1'b0, bps_q}) : trial[12:0];

  // Root sectors rounded up, zero for a zero sector size
  logic [DivSteps-1:0] root_sec;
  always_comb begin
    if (bps_q == '0) begin
      root_sec = '0;
    end else begin
      root_sec = quo_q + DivSteps'(rem_q != '0);
    end
  end

  // Shared multiplier
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] mul_p;
  logic [11:0] cl_rel;

  assign cl_rel = cluster_q - 12'd2;
  assign mul_a  = (state_q == ST_MULA) ? spt_q : {4'b0000, cl_rel};
  assign mul_b  = (state_q == ST_MULA) ? copies_q : spc_q;
  assign mul_p  = mul_a * mul_b;

  // Response assembly
  logic [15:0] word;
  logic [11:0] next_cl;
  logic        bad;
  fat12_pkg::out_rsp_t rsp;

  assign word    = {rdata_q, lo_q};
  assign next_cl = cluster_q[0] ? word[15:4] : word[11:0];
  assign bad     = (cluster_q < 12'd2);

  always_comb begin
    rsp.sector_address = bad ? 32'd0 : acc_q;
    rsp.next_cluster   = next_cl;
    rsp.end_of_chain   = (next_cl >= fat12_pkg::END_OF_CHAIN_MIN);
    rsp.bad_cluster    = bad;
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && is_follow) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CntWidth'(DivSteps - 1)) state_d = ST_MULA;
      ST_MULA: state_d = ST_MULB;
      ST_MULB: state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Payload datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_follow) begin
          cluster_q <= in_req_i.cluster;
          offset_q  <= offset_in;
          rem_q     <= '0;
          quo_q     <= {root_q, 5'b00000};
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          lo_q <= rdata_q;
        end
        rem_q <= rem_next;
        quo_q <= {quo_q[DivSteps-2:0], fits};
      end
      ST_MULA: begin
        mprod_q <= mul_p;
      end
      ST_MULB: begin
        acc_q   <= 32'(mprod_q) + 32'(rsv_q) + 32'(root_sec);
        mprod_q <= mul_p;
      end
      ST_SUM: begin
        acc_q <= acc_q + 32'(mprod_q);
      end
      default: ;
    endcase
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_rsp_o <= rsp;
    end
  end

  // Checks
  a_follow_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_follow |=> state_q == ST_DIV)
    else $error("accepted follow did not start the divider");

  a_div_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= CntWidth'(DivSteps - 1))
    else $error("divider step count out of range");

  a_bad_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_cluster |-> out_rsp_o.sector_address == 32'd0)
    else $error("bad cluster with nonzero sector");

  a_eoc_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.end_of_chain ==
                    (out_rsp_o.next_cluster >= fat12_pkg::END_OF_CHAIN_MIN))
    else $error("end-of-chain flag disagrees with next cluster");

endmodule

// ===== test/fat12_follow_checker.sv =====
`timescale 1ns / 1ps

module fat12_follow_checker #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  fat12_pkg::in_req_t   in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  fat12_pkg::out_rsp_t  out_rsp_i,
  output int unsigned          err_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o
);

  localparam int unsigned MaxReports = 10;

  // Local copy of the allocation table and the disk layout registers
  logic [7:0]  fat_bytes [TABLE_BYTES];
  logic [12:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [15:0] sectors_per_table;
  logic [7:0]  table_copies;
  logic [15:0] root_entries;

  fat12_pkg::out_rsp_t expected_rsp_q [$];

  // Resolve one cluster: table entry, chain end, first data sector
  function automatic fat12_pkg::out_rsp_t resolve_cluster(input logic [11:0] cl);
    fat12_pkg::out_rsp_t rsp;
    logic [12:0] ofs;
    logic [15:0] word;
    logic [11:0] entry;
    logic [31:0] data_base;
    logic [31:0] root_bytes;
    logic [31:0] root_sectors;
    ofs   = 13'((32'(cl) * 32'd3) / 32'd2);
    word  = {fat_bytes[ofs + 13'd1], fat_bytes[ofs]};
    entry = cl[0] ? word[15:4] : word[11:0];
    data_base  = 32'(reserved_sectors) + 32'(sectors_per_table) * 32'(table_copies);
    root_bytes = 32'(root_entries) * 32'd32;
    // a zero sector size leaves no room for a root directory
    root_sectors = 32'd0;
    if (bytes_per_sector != 13'd0) begin
      root_sectors = (root_bytes + 32'(bytes_per_sector) - 32'd1) / 32'(bytes_per_sector);
    end
    rsp.sector_address = 32'd0;
    if (cl >= 12'd2) begin
      rsp.sector_address = data_base + root_sectors
                         + (32'(cl) - 32'd2) * 32'(sectors_per_cluster);
    end
    rsp.next_cluster = entry;
    rsp.end_of_chain = (entry >= fat12_pkg::END_OF_CHAIN_MIN);
    rsp.bad_cluster  = (cl < 12'd2);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    fat12_pkg::out_rsp_t want;
    if (!rst_ni) begin
      bytes_per_sector    = 13'd512;
      sectors_per_cluster = 8'd1;
      reserved_sectors    = 16'd1;
      sectors_per_table   = 16'd9;
      table_copies        = 8'd2;
      root_entries        = 16'd224;
      expected_rsp_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
    end else begin
      // Track register writes; unknown indexes change nothing
      if (cfg_we_i) begin
        case (cfg_index_i)
          fat12_pkg::REG_BYTES_PER_SECTOR:    bytes_per_sector    = cfg_data_i[12:0];
          fat12_pkg::REG_SECTORS_PER_CLUSTER: sectors_per_cluster = cfg_data_i[7:0];
          fat12_pkg::REG_RESERVED_SECTORS:    reserved_sectors    = cfg_data_i;
          fat12_pkg::REG_SECTORS_PER_TABLE:   sectors_per_table   = cfg_data_i;
          fat12_pkg::REG_TABLE_COPIES:        table_copies        = cfg_data_i[7:0];
          fat12_pkg::REG_ROOT_ENTRY_COUNT:    root_entries        = cfg_data_i;
          default: ;
        endcase
      end

      // Store loads, wrapping past the table end, queue the answer of each follow
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.func == fat12_pkg::FUNC_LOAD) begin
          fat_bytes[32'(in_req_i.table_address) % TABLE_BYTES] = in_req_i.table_byte;
        end else begin
          expected_rsp_q.push_back(resolve_cluster(in_req_i.cluster));
        end
      end

      // Compare each response against the oldest follow
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          if (err_count_o < MaxReports) begin
            $display("[%0t] response with no follow outstanding: sector %h next %h",
                     $realtime, out_rsp_i.sector_address, out_rsp_i.next_cluster);
          end
          err_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          checked_o++;
          if (out_rsp_i.sector_address !== want.sector_address ||
              out_rsp_i.next_cluster   !== want.next_cluster   ||
              out_rsp_i.end_of_chain   !== want.end_of_chain   ||
              out_rsp_i.bad_cluster    !== want.bad_cluster) begin
            if (err_count_o < MaxReports) begin
              $display("[%0t] follow mismatch: want sector %h next %h eoc %b bad %b",
                       $realtime, want.sector_address, want.next_cluster,
                       want.end_of_chain, want.bad_cluster);
              $display("[%0t]                   got sector %h next %h eoc %b bad %b",
                       $realtime, out_rsp_i.sector_address, out_rsp_i.next_cluster,
                       out_rsp_i.end_of_chain, out_rsp_i.bad_cluster);
            end
            err_count_o++;
          end
        end
      end

      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ===== test/tb_fat12_chain_lba_follow.sv =====
`timescale 1ns / 1ps

module tb_fat12_chain_lba_follow;

  localparam int unsigned TableBytes    = 8192;
  localparam int unsigned NumLayouts    = 7;
  localparam int unsigned ReqsPerLayout = 220;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned MaxWalk       = 12;
  localparam int unsigned MaxChain      = 8;

  // Register indexes past the end of the list
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  fat12_pkg::in_req_t  in_req;
  logic                out_valid;
  logic                out_stall;
  fat12_pkg::out_rsp_t out_rsp;

  int unsigned err_count;
  int unsigned pending_rsp;
  int unsigned checked_rsp;

  int unsigned reqs_sent    = 0;
  int unsigned loads_sent   = 0;
  int unsigned follows_sent = 0;
  int unsigned holds_done   = 0;
  bit          calm         = 1'b0;
  bit          hold_outputs = 1'b0;

  // What the table holds so far, so follows only touch loaded bytes
  logic [7:0] shadow_bytes [TableBytes];
  bit         shadow_known [TableBytes];

  always #2 clk = ~clk;

  fat12_chain_lba_follow #(
    .TABLE_BYTES(TableBytes)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  fat12_follow_checker #(
    .TABLE_BYTES(TableBytes)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_i  (out_rsp),
    .err_count_o(err_count),
    .pending_o  (pending_rsp),
    .checked_o  (checked_rsp)
  );

  function automatic int unsigned draw_wait();
    if (calm) return 0;
    if ($urandom_range(3, 0) == 0) return 0;
    return $urandom_range(11, 0);
  endfunction

  function automatic logic [12:0] entry_offset(input logic [11:0] cl);
    return 13'((32'(cl) * 32'd3) / 32'd2);
  endfunction

  function automatic logic [11:0] entry_of(input logic [11:0] cl);
    logic [12:0] ofs;
    logic [15:0] word;
    ofs  = entry_offset(cl);
    word = {shadow_bytes[ofs + 13'd1], shadow_bytes[ofs]};
    return cl[0] ? word[15:4] : word[11:0];
  endfunction

  // Mostly valid data clusters, now and then one of the two reserved ones
  function automatic logic [11:0] pick_cluster();
    if ($urandom_range(19, 0) == 0) return 12'($urandom_range(1, 0));
    return 12'($urandom_range(4095, 2));
  endfunction

  // Bias entries toward chain ends and the reserved markers
  function automatic logic [11:0] pick_entry();
    case ($urandom_range(9, 0))
      0, 1:    return 12'($urandom_range(12'hFFF, 12'hFF8));
      2:       return 12'($urandom_range(1, 0));
      3:       return 12'($urandom_range(12'hFF7, 12'hFF0));
      default: return 12'($urandom_range(4095, 2));
    endcase
  endfunction

  // Offer one request after a random gap, hold it until accepted
  task automatic send_req(input fat12_pkg::in_req_t req);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] value);
    fat12_pkg::in_req_t req;
    req.func          = fat12_pkg::FUNC_LOAD;
    req.table_address = addr;
    req.table_byte    = value;
    req.cluster       = 12'($urandom);
    shadow_bytes[addr] = value;
    shadow_known[addr] = 1'b1;
    send_req(req);
    loads_sent++;
  endtask

  // Write a 12-bit entry, keeping the neighbor's nibble in the shared byte
  task automatic put_entry(input logic [11:0] cl, input logic [11:0] value);
    logic [12:0] ofs;
    logic [15:0] word;
    ofs = entry_offset(cl);
    word[7:0]  = shadow_known[ofs] ? shadow_bytes[ofs] : 8'($urandom);
    word[15:8] = shadow_known[ofs + 13'd1] ? shadow_bytes[ofs + 13'd1] : 8'($urandom);
    if (cl[0]) begin
      word[15:4] = value;
    end else begin
      word[11:0] = value;
    end
    load_byte(ofs, word[7:0]);
    load_byte(ofs + 13'd1, word[15:8]);
  endtask

  // Follow one cluster, loading its bytes first if they were never written
  task automatic follow(input logic [11:0] cl);
    fat12_pkg::in_req_t req;
    logic [12:0]        ofs;
    ofs = entry_offset(cl);
    if (!shadow_known[ofs]) load_byte(ofs, 8'($urandom));
    if (!shadow_known[ofs + 13'd1]) load_byte(ofs + 13'd1, 8'($urandom));
    req.func          = fat12_pkg::FUNC_FOLLOW;
    req.table_address = 13'($urandom);
    req.table_byte    = 8'($urandom);
    req.cluster       = cl;
    send_req(req);
    follows_sent++;
  endtask

  // Walk a chain until an end marker, a reserved entry or the step cap
  task automatic walk_chain(input logic [11:0] start);
    logic [11:0] cl;
    logic [11:0] nxt;
    cl = start;
    follow(cl);
    repeat (MaxWalk) begin
      nxt = entry_of(cl);
      if (nxt < 12'd2 || nxt >= fat12_pkg::END_OF_CHAIN_MIN) break;
      cl = nxt;
      follow(cl);
    end
  endtask

  // Link random clusters into a chain, close it, then walk it
  task automatic build_chain(input int unsigned len);
    logic [11:0] links [MaxChain];
    for (int unsigned i = 0; i < len; i++) links[i] = 12'($urandom_range(4095, 2));
    for (int unsigned i = 0; i + 1 < len; i++) put_entry(links[i], links[i + 1]);
    put_entry(links[len - 1], 12'($urandom_range(12'hFFF, 12'hFF8)));
    walk_chain(links[0]);
  endtask

  // Drop valid and wait for every outstanding follow to be answered
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_layout(input int unsigned layout);
    logic [15:0] regs [6];
    case (layout)
      0: regs = '{16'd512, 16'd4, 16'd32, 16'd9, 16'd2, 16'd224};
      1: regs = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0};
      2: regs = '{16'd4096, 16'd128, 16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF};
      3: regs = '{16'd0, 16'd0, 16'd1, 16'd3, 16'd1, 16'd100};
      4: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      default: regs = '{16'($urandom_range(4096, 1)), 16'(1 << $urandom_range(7, 0)),
                        16'($urandom), 16'($urandom_range(300, 0)),
                        16'($urandom_range(4, 0)), 16'($urandom)};
    endcase
    write_reg(fat12_pkg::REG_BYTES_PER_SECTOR,    regs[0]);
    write_reg(fat12_pkg::REG_SECTORS_PER_CLUSTER, regs[1]);
    write_reg(fat12_pkg::REG_RESERVED_SECTORS,    regs[2]);
    write_reg(fat12_pkg::REG_SECTORS_PER_TABLE,   regs[3]);
    write_reg(fat12_pkg::REG_TABLE_COPIES,        regs[4]);
    write_reg(fat12_pkg::REG_ROOT_ENTRY_COUNT,    regs[5]);
    // writes past the register list must not disturb the layout
    if (layout == 3) begin
      write_reg(REG_SPARE_6, 16'($urandom));
      write_reg(REG_SPARE_7, 16'hFFFF);
    end
    cfg_we <= 1'b0;
  endtask

  // Reserved clusters, both parities, the table ends, the top store byte
  task automatic run_directed();
    put_entry(12'd0, 12'hFF0);
    put_entry(12'd1, 12'hFFF);
    follow(12'd0);
    follow(12'd1);
    put_entry(12'd2, 12'd3);
    put_entry(12'd3, 12'hFFF);
    walk_chain(12'd2);
    put_entry(12'd4095, 12'hFF7);
    follow(12'd4095);
    put_entry(12'd4094, fat12_pkg::END_OF_CHAIN_MIN);
    follow(12'd4094);
    load_byte(13'h1FFF, 8'hFF);
    load_byte(13'h1FFF, 8'h00);
  endtask

  task automatic run_layout(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pause_at;
    int unsigned pick;
    bit          paused;
    stop_at  = reqs_sent + budget;
    pause_at = reqs_sent + budget / 2;
    paused   = 1'b0;
    while (reqs_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        load_byte(13'($urandom), 8'($urandom));
      end else if (pick < 30) begin
        put_entry(pick_cluster(), pick_entry());
      end else if (pick < 65) begin
        build_chain($urandom_range(MaxChain, 2));
      end else if (pick < 85) begin
        walk_chain(pick_cluster());
      end else begin
        follow(pick_cluster());
      end
      // halfway, let the block run dry before sending more
      if (!paused && reqs_sent >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Response side: random stalls, one long hold when asked
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_outputs) begin
        hold = HoldCycles;
        hold_outputs = 1'b0;
        holds_done++;
      end else begin
        hold = draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    cfg_we    = 1'b0;
    cfg_index = fat12_pkg::REG_BYTES_PER_SECTOR;
    cfg_data  = 16'd0;
    in_valid  = 1'b0;
    in_req    = '0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int unsigned layout = 0; layout < NumLayouts; layout++) begin
      drain_results();
      calm = (layout == 1 || layout == 4);
      set_layout(layout);
      hold_outputs = (layout == 2);
      run_layout(ReqsPerLayout);
    end
    calm = 1'b0;
    drain_results();

    $display("Covered %0d requests (%0d table loads, %0d cluster follows) over %0d layouts,",
             reqs_sent, loads_sent, follows_sent, NumLayouts + 1);
    $display("%0d long output holds; %0d responses compared, %0d mismatched, %0d missing.",
             holds_done, checked_rsp, err_count, pending_rsp);
    if (err_count == 0 && pending_rsp == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fat12_pkg.sv
design/fat12_chain_lba_follow.sv
test/fat12_follow_checker.sv
test/tb_fat12_chain_lba_follow.sv
